// File: hw/rtl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length scanline decoder.
// No dependencies; imported by every module of the block.
package tgarle_pkg;

  // Largest pixel size in bytes that the decoder is built for
  localparam int MaxPixelBytes = 4;

  // Entries in the queue between front and back
  localparam int QueueDepth = 2;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_BYTES_PER_PIXEL = 2'd0,
    REG_LINE_WIDTH      = 2'd1,
    REG_IMAGE_HEIGHT    = 2'd2
  } reg_index_t;

  // Reset values of the registers
  localparam logic [2:0]  BppReset    = 3'd3;
  localparam logic [15:0] WidthReset  = 16'd640;
  localparam logic [15:0] HeightReset = 16'd480;

  // Header byte threshold and repeat bias
  localparam logic [7:0] RepeatThreshold = 8'd128;
  localparam logic [7:0] RepeatBias      = 8'd127;

  // Result kinds
  typedef enum logic [1:0] {
    STATUS_PIXEL = 2'd0,
    STATUS_END   = 2'd1,
    STATUS_TRUNC = 2'd2
  } status_t;

  // Item moved from the front to the back
  typedef struct packed {
    logic       end_of_stream;
    logic [7:0] data_byte;
  } item_t;

  // Configuration write handed to the back
  typedef struct packed {
    logic       wr;
    reg_index_t index;
    logic [15:0] data;
  } cfg_wr_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic [15:0] column;
    logic [15:0] line_index;
    logic        end_of_line;
    logic        end_of_image;
  } result_t;

endpackage

// File: hw/rtl/tgarle_front.sv
// Input stage of the TGA run-length decoder: registers stream items and
// sorts data bytes from end-of-stream marks. Uses tgarle_pkg.
module tgarle_front
  import tgarle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_eos,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output item_t      out_item
);

  logic  stage_valid;
  item_t stage_item;

  assign in_ready  = !stage_valid || out_ready;
  assign out_valid = stage_valid;
  assign out_item  = stage_item;

  // Hold the stage flag; refill whenever the stage drains
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Capture the item; the byte means nothing on an end mark, so zero it
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item.end_of_stream <= in_eos;
      stage_item.data_byte     <= in_eos ? 8'd0 : in_byte;
    end
  end

endmodule

// File: hw/rtl/tgarle_queue.sv
// Short queue between the front and the back of the TGA decoder.
// Uses tgarle_pkg for the item type and depth.
module tgarle_queue
  import tgarle_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            entries [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CntW'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_pop_not_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_count_track : assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

// File: hw/rtl/tgarle_back.sv
// Packet decoder of the TGA run-length decoder: parses headers, builds
// pixels, tracks the scan position and holds the result register.
// Uses tgarle_pkg.
module tgarle_back
  import tgarle_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = MaxPixelBytes
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int AsmW = 8 * MAX_PIXEL_BYTES;
  localparam int PosW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam logic [2:0] MaxBytes = 3'(MAX_PIXEL_BYTES);

  // Configuration registers
  logic [2:0]  bytes_per_pixel;
  logic [15:0] line_width;
  logic [15:0] image_height;

  // Decoding state
  logic            packet_is_repeat;
  logic [7:0]      packet_remaining;
  logic [PosW-1:0] byte_position;
  logic [AsmW-1:0] pixel_assembly;
  logic [15:0]     column_count;
  logic [15:0]     line_count;

  logic            packet_is_repeat_next;
  logic [7:0]      packet_remaining_next;
  logic [PosW-1:0] byte_position_next;
  logic [AsmW-1:0] pixel_assembly_next;
  logic [15:0]     column_count_next;
  logic [15:0]     line_count_next;

  // Working values
  logic [2:0]      eff_bytes;
  logic [15:0]     eff_width;
  logic [15:0]     eff_height;
  logic [AsmW-1:0] pixel_full;
  logic            pixel_done;
  logic [15:0]     left;
  logic [7:0]      run;
  logic            eol;
  logic            eoi;
  logic            clean;
  logic            produces;
  logic            take;
  result_t         result_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BppReset;
      line_width      <= WidthReset;
      image_height    <= HeightReset;
    end else if (cfg.wr) begin
      case (cfg.index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data[2:0];
        REG_LINE_WIDTH:      line_width      <= cfg.data;
        REG_IMAGE_HEIGHT:    image_height    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp register values into the working range
  always_comb begin
    if (bytes_per_pixel == 3'd0) begin
      eff_bytes = 3'd1;
    end else if (bytes_per_pixel > MaxBytes) begin
      eff_bytes = MaxBytes;
    end else begin
      eff_bytes = bytes_per_pixel;
    end
    eff_width  = (line_width == 16'd0) ? 16'd1 : line_width;
    eff_height = (image_height == 16'd0) ? 16'd1 : image_height;
  end

  // Insert the incoming byte into its lane of the pixel
  always_comb begin
    pixel_full = pixel_assembly;
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      if (byte_position == PosW'(i)) begin
        pixel_full[i*8 +: 8] = item.data_byte;
      end
    end
  end

  // Run length, clipped at the line end, and line and image marks
  always_comb begin
    pixel_done = ({1'b0, 4'(byte_position)} + 5'd1) >= {2'b0, eff_bytes};
    left = (column_count < eff_width) ? (eff_width - column_count) : 16'd1;
    if (packet_is_repeat) begin
      run = ({8'd0, packet_remaining} < left) ? packet_remaining : left[7:0];
    end else begin
      run = 8'd1;
    end
    eol   = ({8'd0, run} >= left);
    eoi   = eol && (({1'b0, line_count} + 17'd1) >= {1'b0, eff_height});
    clean = (packet_remaining == 8'd0) && (column_count == 16'd0) &&
            (line_count == 16'd0);
    produces = item.end_of_stream ||
               ((packet_remaining != 8'd0) && pixel_done);
  end

  // Next state and result of the item at the head of the queue
  always_comb begin
    packet_is_repeat_next = packet_is_repeat;
    packet_remaining_next = packet_remaining;
    byte_position_next    = byte_position;
    pixel_assembly_next   = pixel_assembly;
    column_count_next     = column_count;
    line_count_next       = line_count;

    result_next.status       = STATUS_PIXEL;
    result_next.pixel_value  = 32'(pixel_full);
    result_next.run_length   = run;
    result_next.column       = column_count;
    result_next.line_index   = line_count;
    result_next.end_of_line  = eol;
    result_next.end_of_image = eoi;

    if (item.end_of_stream) begin
      // Report the end and drop all stream state
      result_next.status       = clean ? STATUS_END : STATUS_TRUNC;
      result_next.pixel_value  = '0;
      result_next.run_length   = '0;
      result_next.column       = '0;
      result_next.line_index   = '0;
      result_next.end_of_line  = 1'b0;
      result_next.end_of_image = 1'b0;
      packet_is_repeat_next = 1'b0;
      packet_remaining_next = '0;
      byte_position_next    = '0;
      pixel_assembly_next   = '0;
      column_count_next     = '0;
      line_count_next       = '0;
    end else if (packet_remaining == 8'd0) begin
      // Open a packet from its header byte
      packet_is_repeat_next = (item.data_byte >= RepeatThreshold);
      packet_remaining_next = (item.data_byte >= RepeatThreshold) ?
                              (item.data_byte - RepeatBias) :
                              (item.data_byte + 8'd1);
      byte_position_next    = '0;
      pixel_assembly_next   = '0;
    end else if (!pixel_done) begin
      // Collect one more byte of the pixel
      byte_position_next  = byte_position + 1'b1;
      pixel_assembly_next = pixel_full;
    end else begin
      // Finish the pixel and advance the scan position
      packet_remaining_next = packet_is_repeat ? 8'd0 : (packet_remaining - 8'd1);
      if (eol) begin
        packet_remaining_next = 8'd0;
        column_count_next     = 16'd0;
        line_count_next       = eoi ? 16'd0 : (line_count + 16'd1);
      end else begin
        column_count_next = column_count + {8'd0, run};
      end
      byte_position_next  = '0;
      pixel_assembly_next = '0;
    end
  end

  // An item that gives no result never waits on the result register
  assign take       = item_valid && (!produces || !res_valid || res_ready);
  assign item_ready = take;

  // Advance the decoding state
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_is_repeat <= 1'b0;
      packet_remaining <= '0;
      byte_position    <= '0;
      pixel_assembly   <= '0;
      column_count     <= '0;
      line_count       <= '0;
    end else if (take) begin
      packet_is_repeat <= packet_is_repeat_next;
      packet_remaining <= packet_remaining_next;
      byte_position    <= byte_position_next;
      pixel_assembly   <= pixel_assembly_next;
      column_count     <= column_count_next;
      line_count       <= line_count_next;
    end
  end

  // Hold a result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && produces) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && produces) begin
      res <= result_next;
    end
  end

  a_run_nonzero : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == STATUS_PIXEL) |-> res.run_length != 8'd0)
    else $error("pixel result with empty run");

  a_image_ends_line : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.end_of_image) |-> res.end_of_line)
    else $error("image end without line end");

  a_eos_clears : assert property (@(posedge clk) disable iff (rst)
    (take && item.end_of_stream) |=>
      (column_count == 16'd0 && line_count == 16'd0 && packet_remaining == 8'd0))
    else $error("stream state kept after end of stream");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res))
    else $error("pending result overwritten");

endmodule

// File: hw/rtl/tga_rle_scanline_decoder_unit.sv
// Top level of the TGA run-length scanline decoder.
// Instantiates tgarle_front, tgarle_queue and tgarle_back; uses tgarle_pkg.
//
// The decoder takes one compressed byte per clock cycle on the slave stream
// while no pending result stalls it and gives one result per finished pixel
// on the master stream; header bytes and bytes inside a multi-byte pixel give
// none. A byte passes the input stage register and the queue to the packet
// decoder, which sets that rate: it updates the packet count, pixel lanes and
// scan position of each byte it takes, and its result register holds results.
// The input stage and a two-entry queue let the slave side take up to three
// more bytes while a result waits on the master side. Registers are written
// through the configuration channel, which is always ready, and should only
// be written while the block is idle.
module tga_rle_scanline_decoder_unit
  import tgarle_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = MaxPixelBytes
) (
  input  logic        clk,
  input  logic        rst,
  // Compressed input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] end_of_stream
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] pixel_value, [39:32] run_length,
                                 // [55:40] column, [71:56] line_index,
                                 // [72] end_of_line, [79:73] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast,   // end_of_image
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic    front_valid;
  logic    front_ready;
  item_t   front_item;
  logic    queue_valid;
  logic    queue_ready;
  item_t   queue_item;
  cfg_wr_t cfg_wr;
  result_t res;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.wr    = cfg_valid;
  assign cfg_wr.index = reg_index_t'(cfg_index);
  assign cfg_wr.data  = cfg_data;

  tgarle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_eos    (s_tuser[0]),
    .in_byte   (s_tdata),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  tgarle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  tgarle_back #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_wr),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  // Pack the result fields onto the stream
  assign m_tdata = {7'd0, res.end_of_line, res.line_index, res.column,
                    res.run_length, res.pixel_value};
  assign m_tuser = res.status;
  assign m_tlast = res.end_of_image;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the TGA run-length scanline decoder.
// Depends on tgarle_pkg and tga_rle_scanline_decoder_unit only.
// Streams packets under random idling and checks each run against a predictor.
module tb
  import tgarle_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the run items of the decoder and holds those still due
  class rle_run_tracker;
    logic [2:0]  bpp;
    logic [15:0] width;
    logic [15:0] height;
    bit          rpt;
    int unsigned remaining;
    int unsigned pos;
    int unsigned col;
    int unsigned line;
    logic [31:0] assembly;
    result_t     runs_due[$];
    int unsigned faults;

    function new();
      bpp    = BppReset;
      width  = WidthReset;
      height = HeightReset;
      faults = 0;
      restart();
    endfunction

    function void restart();
      rpt       = 1'b0;
      remaining = 0;
      pos       = 0;
      col       = 0;
      line      = 0;
      assembly  = '0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] val);
      case (idx)
        REG_BYTES_PER_PIXEL: bpp = val[2:0];
        REG_LINE_WIDTH:      width = val;
        REG_IMAGE_HEIGHT:    height = val;
        default: ;
      endcase
    endfunction

    // Advance the decoding state by one accepted item
    function void take_item(bit eos, logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned nbytes;
      int unsigned left;
      int unsigned run;
      result_t     r;
      w = (width == 0) ? 1 : width;
      h = (height == 0) ? 1 : height;
      nbytes = (bpp == 0) ? 1 : (bpp > MaxPixelBytes) ? MaxPixelBytes : bpp;
      r = '0;
      // end of stream: clean only at the very start of an image
      if (eos) begin
        r.status = (remaining == 0 && col == 0 && line == 0) ? STATUS_END : STATUS_TRUNC;
        runs_due.push_back(r);
        restart();
        return;
      end
      // packet header
      if (remaining == 0) begin
        rpt = (b >= RepeatThreshold);
        remaining = rpt ? (int'(b) - int'(RepeatBias)) : (int'(b) + 1);
        pos = 0;
        assembly = '0;
        return;
      end
      // gather pixel bytes, lowest first
      assembly |= 32'(b) << (8 * pos);
      if (pos + 1 < nbytes) begin
        pos++;
        return;
      end
      // clip the run at the line end; a position past the end gives one pixel
      left = (col < w) ? (w - col) : 1;
      run = rpt ? ((remaining < left) ? remaining : left) : 1;
      r.status       = STATUS_PIXEL;
      r.pixel_value  = assembly;
      r.run_length   = run[7:0];
      r.column       = col[15:0];
      r.line_index   = line[15:0];
      r.end_of_line  = (run >= left);
      r.end_of_image = r.end_of_line && (line + 1 >= h);
      remaining = rpt ? 0 : remaining - 1;
      if (r.end_of_line) begin
        remaining = 0;
        col = 0;
        line = r.end_of_image ? 0 : line + 1;
      end else begin
        col += run;
      end
      pos = 0;
      assembly = '0;
      runs_due.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        faults++;
      end
    endfunction

    // Compare one delivered run with the oldest one due
    function void check_run(result_t got);
      result_t want;
      if (runs_due.size() == 0) begin
        $error("unexpected run item: status %0d pixel %0h", got.status, got.pixel_value);
        faults++;
        return;
      end
      want = runs_due.pop_front();
      match_field("status", 32'(want.status), 32'(got.status));
      match_field("pixel_value", want.pixel_value, got.pixel_value);
      match_field("run_length", 32'(want.run_length), 32'(got.run_length));
      match_field("column", 32'(want.column), 32'(got.column));
      match_field("line_index", 32'(want.line_index), 32'(got.line_index));
      match_field("end_of_line", 32'(want.end_of_line), 32'(got.end_of_line));
      match_field("end_of_image", 32'(want.end_of_image), 32'(got.end_of_image));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bit          calm = 1'b0;
  int          sent = 0;
  int          cur_bytes = 3;
  rle_run_tracker runs = new();

  // Per-phase formats for the random part, extremes included
  int bpp_set[12]    = '{1, 4, 0, 7, 2, 3, 1, 4, 5, 3, 2, 6};
  int width_set[12]  = '{1, 3, 0, 65535, 5, 2, 7, 1, 4, 16, 3, 2};
  int height_set[12] = '{1, 2, 3, 0, 65535, 1, 4, 2, 3, 2, 1, 5};

  tga_rle_scanline_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 23);
  end

  // Note accepted items and register writes; check delivered runs
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        runs.set_reg(reg_index_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready)
        runs.take_item(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) begin
        got.status       = status_t'(m_tuser);
        got.pixel_value  = m_tdata[31:0];
        got.run_length   = m_tdata[39:32];
        got.column       = m_tdata[55:40];
        got.line_index   = m_tdata[71:56];
        got.end_of_line  = m_tdata[72];
        got.end_of_image = m_tlast;
        runs.check_run(got);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tga_rle_scanline_decoder_unit: mismatch");
    $finish;
  end

  // Offer one item, with random idle cycles before it
  task automatic push_byte(bit eos, logic [7:0] b);
    while (!calm && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= eos;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Wait until every run due has arrived and the pipeline has emptied
  task automatic settle();
    s_tvalid <= 1'b0;
    while (runs.runs_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_format(int bpp, int width, int height);
    settle();
    write_reg(REG_BYTES_PER_PIXEL, 16'(bpp));
    write_reg(REG_LINE_WIDTH, 16'(width));
    write_reg(REG_IMAGE_HEIGHT, 16'(height));
    cur_bytes = (bpp == 0) ? 1 : (bpp > MaxPixelBytes) ? MaxPixelBytes : bpp;
  endtask

  // Header for a run of count pixels, then nbytes random pixel bytes
  task automatic send_packet(bit rpt, int count, int nbytes);
    push_byte(1'b0, rpt ? 8'(int'(RepeatBias) + count) : 8'(count - 1));
    repeat (nbytes) push_byte(1'b0, 8'($urandom_range(255)));
  endtask

  initial begin
    int  quota;
    int  pick;
    int  count;
    int  full;
    bit  rpt;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // end of stream right after reset: clean end
    push_byte(1'b1, 8'h5A);
    set_format(1, 4, 2);
    // shortest repeat, then longest repeat clipped at the line end
    push_byte(1'b0, 8'h80);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'hFF);
    // longest raw packet: the leftover count is dropped at the image end
    push_byte(1'b0, 8'h7F);
    push_byte(1'b0, 8'h12);
    push_byte(1'b0, 8'h34);
    push_byte(1'b0, 8'h56);
    push_byte(1'b0, 8'h78);
    // shortest raw packet, then truncation mid-line
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'hA5);
    push_byte(1'b1, 8'h00);
    // shrink the line under a position already past its end
    set_format(1, 8, 2);
    push_byte(1'b0, 8'h84);
    push_byte(1'b0, 8'h11);
    set_format(1, 3, 1);
    push_byte(1'b0, 8'h01);
    push_byte(1'b0, 8'h22);
    push_byte(1'b0, 8'h33);
    push_byte(1'b1, 8'hC3);
    // widest pixel, repeat to the end of a one-line image, then clean end
    set_format(4, 2, 1);
    push_byte(1'b0, 8'h81);
    push_byte(1'b0, 8'h01);
    push_byte(1'b0, 8'h02);
    push_byte(1'b0, 8'h03);
    push_byte(1'b0, 8'h04);
    push_byte(1'b1, 8'hFF);

    // Random part: mostly whole packets, some noise and cut-off packets
    for (int p = 0; p < 12; p++) begin
      set_format(bpp_set[p], width_set[p], height_set[p]);
      calm <= (p == 5 || p == 6);
      quota = sent + 32;
      while (sent < quota) begin
        pick = $urandom_range(99);
        rpt = $urandom_range(1);
        if (rpt)
          count = ($urandom_range(9) == 0) ? $urandom_range(9, 128) : $urandom_range(1, 4);
        else
          count = $urandom_range(1, 6);
        full = (rpt ? 1 : count) * cur_bytes;
        if (pick < 80) begin
          send_packet(rpt, count, full);
        end else if (pick < 88) begin
          push_byte(1'b0, 8'($urandom_range(255)));
        end else if (pick < 94) begin
          send_packet(rpt, count, $urandom_range(full - 1));
          push_byte(1'b1, 8'($urandom_range(255)));
        end else begin
          push_byte(1'b1, 8'($urandom_range(255)));
        end
      end
    end

    calm <= 1'b0;
    settle();
    if (runs.faults == 0)
      $display("tga_rle_scanline_decoder_unit: match");
    else
      $display("tga_rle_scanline_decoder_unit: mismatch");
    $finish;
  end

endmodule
